// ===== rtl/tcsp_pkg.sv =====
// Shared types, codes and constants for the table container stream parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package tcsp_pkg;

  // default bounds, used as the defaults of the top level parameters
  localparam int DEF_MAX_TABLES   = 64;
  localparam int DEF_NAME_LIMIT   = 32;
  localparam int DEF_MAX_ELEMENTS = 1048576;

  // result queue geometry
  localparam int FIFO_AW    = 2;
  localparam int FIFO_DEPTH = 1 << FIFO_AW;

  // container signature bytes
  localparam logic [7:0] SIG_B0 = 8'h51;
  localparam logic [7:0] SIG_B1 = 8'h50;
  localparam logic [7:0] SIG_B2 = 8'h54;
  localparam logic [7:0] SIG_B3 = 8'h31;

  typedef enum logic [2:0] {
    PH_MAGIC   = 3'd0,
    PH_COUNT   = 3'd1,
    PH_NAMELEN = 3'd2,
    PH_NAME    = 3'd3,
    PH_ROWS    = 3'd4,
    PH_COLS    = 3'd5,
    PH_DATA    = 3'd6,
    PH_DONE    = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NAME = 2'd0,
    KIND_DIMS = 2'd1,
    KIND_ELEM = 2'd2,
    KIND_END  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [5:0]  table_index;
    logic [15:0] value;
    logic [19:0] element_index;
    logic [20:0] row_count;
    logic [20:0] column_count;
    logic        status;
    logic        run_end;
  } out_item_t;

  // write enables into the result queue: first slot, then second slot
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

  function automatic logic [7:0] sig_byte(input logic [1:0] pos);
    logic [7:0] b;
    case (pos)
      2'd0:    b = SIG_B0;
      2'd1:    b = SIG_B1;
      2'd2:    b = SIG_B2;
      default: b = SIG_B3;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tcsp_parser.sv =====
// Parse state and per-byte result generation for the container stream.
// Depends on tcsp_pkg; feeds up to two result items per byte to tcsp_out_fifo.
`default_nettype none

module tcsp_parser #(
  parameter int MAX_TABLES   = tcsp_pkg::DEF_MAX_TABLES,
  parameter int NAME_LIMIT   = tcsp_pkg::DEF_NAME_LIMIT,
  parameter int MAX_ELEMENTS = tcsp_pkg::DEF_MAX_ELEMENTS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  output tcsp_pkg::push_t     push,
  output tcsp_pkg::out_item_t item_a,
  output tcsp_pkg::out_item_t item_b
);
  import tcsp_pkg::*;

  localparam int TW = $clog2(MAX_TABLES + 1);
  localparam int NW = $clog2(NAME_LIMIT + 1);
  localparam int EW = $clog2(MAX_ELEMENTS + 1);
  localparam int CW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam logic [31:0]     MaxTabW  = 32'(MAX_TABLES);
  localparam logic [31:0]     NameLimW = 32'(NAME_LIMIT);
  localparam logic [31:0]     MaxElemW = 32'(MAX_ELEMENTS);
  localparam logic [2*EW-1:0] MaxProd  = (2*EW)'(MAX_ELEMENTS);

  phase_t         phase_r, phase_nxt;
  logic [1:0]     pos_r, pos_nxt;
  logic [23:0]    acc_r, acc_nxt;
  logic [TW-1:0]  tables_r, tables_nxt;
  logic [TW-1:0]  table_r, table_nxt;
  logic [NW-1:0]  name_left_r, name_left_nxt;
  logic [EW-1:0]  rows_r, rows_nxt;
  logic [EW-1:0]  elem_left_r, elem_left_nxt;
  logic [CW-1:0]  elem_cnt_r, elem_cnt_nxt;
  logic [7:0]     low_hold_r, low_hold_nxt;
  logic           err_r, err_nxt;

  logic           word_phase;
  logic           word_done;
  logic [31:0]    word;
  logic [EW-1:0]  cols_fit;
  logic [2*EW-1:0] total;
  logic [TW-1:0]  table_inc;
  logic [31:0]    rows_ext;
  logic [31:0]    table_ext;
  logic [31:0]    cnt_ext;

  logic           r0_valid;
  out_item_t      r0;
  out_item_t      st_item;

  assign word_phase = (phase_r == PH_COUNT) || (phase_r == PH_NAMELEN) ||
                      (phase_r == PH_ROWS) || (phase_r == PH_COLS);
  assign word_done  = word_phase && (pos_r == 2'd3);
  assign word       = {in_byte, acc_r};
  assign cols_fit   = word[EW-1:0];
  assign total      = (2*EW)'(rows_r) * (2*EW)'(cols_fit);
  assign table_inc  = table_r + TW'(1);
  assign rows_ext   = 32'(rows_r);
  assign table_ext  = 32'(table_r);
  assign cnt_ext    = 32'(elem_cnt_r);

  // next state
  always_comb begin
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    acc_nxt       = acc_r;
    tables_nxt    = tables_r;
    table_nxt     = table_r;
    name_left_nxt = name_left_r;
    rows_nxt      = rows_r;
    elem_left_nxt = elem_left_r;
    elem_cnt_nxt  = elem_cnt_r;
    low_hold_nxt  = low_hold_r;
    err_nxt       = err_r;
    if (!err_r) begin
      if (word_phase) begin
        if (pos_r != 2'd3) begin
          acc_nxt = acc_r | ({16'h0000, in_byte} << {pos_r, 3'b000});
          pos_nxt = pos_r + 2'd1;
        end else begin
          acc_nxt = '0;
          pos_nxt = '0;
        end
      end
      case (phase_r)
        PH_MAGIC: begin
          if (in_byte != sig_byte(pos_r)) begin
            err_nxt = 1'b1;
          end else if (pos_r == 2'd3) begin
            pos_nxt   = '0;
            phase_nxt = PH_COUNT;
          end else begin
            pos_nxt = pos_r + 2'd1;
          end
        end
        PH_COUNT: begin
          if (word_done) begin
            if (word == 32'd0 || word > MaxTabW) begin
              err_nxt = 1'b1;
            end else begin
              tables_nxt = word[TW-1:0];
              table_nxt  = '0;
              phase_nxt  = PH_NAMELEN;
            end
          end
        end
        PH_NAMELEN: begin
          if (word_done) begin
            if (word == 32'd0 || word > NameLimW) begin
              err_nxt = 1'b1;
            end else begin
              name_left_nxt = word[NW-1:0];
              phase_nxt     = PH_NAME;
            end
          end
        end
        PH_NAME: begin
          name_left_nxt = name_left_r - NW'(1);
          if (name_left_r == NW'(1)) begin
            phase_nxt = PH_ROWS;
          end
        end
        PH_ROWS: begin
          if (word_done) begin
            if (word == 32'd0 || word > MaxElemW) begin
              err_nxt = 1'b1;
            end else begin
              rows_nxt  = word[EW-1:0];
              phase_nxt = PH_COLS;
            end
          end
        end
        PH_COLS: begin
          // an oversized column count fails on its own, as the product sees only its low bits
          if (word_done) begin
            if (word == 32'd0 || word > MaxElemW || total > MaxProd) begin
              err_nxt = 1'b1;
            end else begin
              elem_left_nxt = total[EW-1:0];
              elem_cnt_nxt  = '0;
              phase_nxt     = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          if (pos_r == 2'd0) begin
            low_hold_nxt = in_byte;
            pos_nxt      = 2'd1;
          end else begin
            pos_nxt       = '0;
            elem_cnt_nxt  = elem_cnt_r + CW'(1);
            elem_left_nxt = elem_left_r - EW'(1);
            if (elem_left_r == EW'(1)) begin
              table_nxt = table_inc;
              phase_nxt = (table_inc >= tables_r) ? PH_DONE : PH_NAMELEN;
            end
          end
        end
        default: begin
          // anything after the final element
          err_nxt = 1'b1;
        end
      endcase
    end
  end

  // result generation
  always_comb begin
    r0_valid = 1'b0;
    r0       = '0;
    if (!err_nxt) begin
      case (phase_r)
        PH_NAME: begin
          r0_valid       = 1'b1;
          r0.kind        = KIND_NAME;
          r0.table_index = table_ext[5:0];
          r0.value       = {8'h00, in_byte};
        end
        PH_COLS: begin
          r0_valid        = word_done;
          r0.kind         = KIND_DIMS;
          r0.table_index  = table_ext[5:0];
          r0.row_count    = rows_ext[20:0];
          r0.column_count = word[20:0];
        end
        PH_DATA: begin
          r0_valid         = (pos_r == 2'd1);
          r0.kind          = KIND_ELEM;
          r0.table_index   = table_ext[5:0];
          r0.value         = {in_byte, low_hold_r};
          r0.element_index = cnt_ext[19:0];
        end
        default: begin
          r0_valid = 1'b0;
        end
      endcase
    end

    st_item         = '0;
    st_item.kind    = KIND_END;
    st_item.status  = err_nxt || (phase_nxt != PH_DONE);
    st_item.run_end = 1'b1;

    push.first   = in_fire && (r0_valid || in_last);
    push.second  = in_fire && r0_valid && in_last;
    item_a       = r0_valid ? r0 : st_item;
    item_a.run_end = !(r0_valid && in_last);
    item_b       = st_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (in_fire && in_last)) begin
      phase_r     <= PH_MAGIC;
      pos_r       <= '0;
      acc_r       <= '0;
      tables_r    <= '0;
      table_r     <= '0;
      name_left_r <= '0;
      rows_r      <= '0;
      elem_left_r <= '0;
      elem_cnt_r  <= '0;
      low_hold_r  <= '0;
      err_r       <= 1'b0;
    end else if (in_fire) begin
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      acc_r       <= acc_nxt;
      tables_r    <= tables_nxt;
      table_r     <= table_nxt;
      name_left_r <= name_left_nxt;
      rows_r      <= rows_nxt;
      elem_left_r <= elem_left_nxt;
      elem_cnt_r  <= elem_cnt_nxt;
      low_hold_r  <= low_hold_nxt;
      err_r       <= err_nxt;
    end
  end

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_last |=> phase_r == PH_MAGIC && !err_r && pos_r == 2'd0)
    else $error("parser did not return to the signature phase after last beat");

  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    err_r && !(in_fire && in_last) |=> err_r)
    else $error("format error cleared before end of stream");

  a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
    push.second |-> push.first)
    else $error("second result pushed without the first");

  a_data_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> elem_left_r != '0)
    else $error("element phase with no elements left");

endmodule

`default_nettype wire

// ===== rtl/tcsp_out_fifo.sv =====
// Four-entry result queue taking up to two results per cycle, one out per beat.
// Depends on tcsp_pkg for the result item type and queue depth.
`default_nettype none

module tcsp_out_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  tcsp_pkg::push_t     push,
  input  tcsp_pkg::out_item_t item_a,
  input  tcsp_pkg::out_item_t item_b,
  output logic                room,
  output logic                out_valid,
  input  logic                out_stall,
  output tcsp_pkg::out_item_t out_item
);
  import tcsp_pkg::*;

  out_item_t          mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_r, wr_nxt;
  logic [FIFO_AW-1:0] rd_r, rd_nxt;
  logic [FIFO_AW:0]   count_r, count_nxt;
  logic               pop;
  logic [FIFO_AW-1:0] wr_plus1;

  assign out_valid = (count_r != '0);
  assign pop       = out_valid && !out_stall;
  // room for the worst case of two results from one byte
  assign room      = (count_r <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
  assign out_item  = mem[rd_r];
  assign wr_plus1  = wr_r + FIFO_AW'(1);

  always_comb begin
    wr_nxt    = wr_r + FIFO_AW'(push.first) + FIFO_AW'(push.second);
    rd_nxt    = rd_r + FIFO_AW'(pop);
    count_nxt = count_r + (FIFO_AW+1)'(push.first) + (FIFO_AW+1)'(push.second)
                - (FIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.first) begin
      mem[wr_r] <= item_a;
    end
    if (push.second) begin
      mem[wr_plus1] <= item_b;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("result queue overfilled");

  a_push_with_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.first |-> room)
    else $error("result pushed without room for two");

  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !push.first && count_r == (FIFO_AW+1)'(1) |=> !out_valid)
    else $error("queue still valid after draining its only entry");

endmodule

`default_nettype wire

// ===== rtl/table_container_stream_parser.sv =====
// Table container stream parser: byte-wide input, one result item per output beat.
// Input channel: in_data_byte with in_last on the final byte of a stream, taken
// on in_valid high with in_stall low. Output channel: one result per beat on
// out_valid high with out_stall low; out_run_end marks the last result of a byte.
// Each accepted byte is parsed in the cycle it arrives; its results are registered
// into a four-entry queue behind any results already waiting. Throughput is one
// byte per cycle while in_stall is low. A byte yields at most two results (the
// final byte of a stream may add the end status to a name byte, dimensions or
// element); in_stall rises while the queue holds fewer than two free places,
// so with the receiver stalled an empty queue takes at most three more
// result-bearing bytes before the input backs up, and then every byte waits.
// After a format error nothing is emitted until the last byte, which always
// gives the end status; parse state then returns to its reset values.
// Reset (rst_n low, synchronous) empties the queue and restarts parsing at the
// signature; no clearing pass is needed.
// Uses tcsp_pkg, tcsp_parser and tcsp_out_fifo.
`default_nettype none

module table_container_stream_parser #(
  parameter int MAX_TABLES   = tcsp_pkg::DEF_MAX_TABLES,
  parameter int NAME_LIMIT   = tcsp_pkg::DEF_NAME_LIMIT,
  parameter int MAX_ELEMENTS = tcsp_pkg::DEF_MAX_ELEMENTS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [5:0]  out_table_index,
  output logic [15:0] out_value,
  output logic [19:0] out_element_index,
  output logic [20:0] out_row_count,
  output logic [20:0] out_column_count,
  output logic        out_status,
  output logic        out_run_end
);
  import tcsp_pkg::*;

  push_t     push;
  out_item_t item_a;
  out_item_t item_b;
  out_item_t head;
  logic      room;
  logic      in_fire;

  assign in_stall = !room;
  assign in_fire  = in_valid && room;

  tcsp_parser #(
    .MAX_TABLES  (MAX_TABLES),
    .NAME_LIMIT  (NAME_LIMIT),
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_fire(in_fire),
    .in_byte(in_data_byte),
    .in_last(in_last),
    .push   (push),
    .item_a (item_a),
    .item_b (item_b)
  );

  tcsp_out_fifo u_out_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .item_a   (item_a),
    .item_b   (item_b),
    .room     (room),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (head)
  );

  assign out_kind          = head.kind;
  assign out_table_index   = head.table_index;
  assign out_value         = head.value;
  assign out_element_index = head.element_index;
  assign out_row_count     = head.row_count;
  assign out_column_count  = head.column_count;
  assign out_status        = head.status;
  assign out_run_end       = head.run_end;

endmodule

`default_nettype wire

// ===== sim/tcsp_result_checker.sv =====
// Result checker for the table container stream parser: watches both channels,
// parses every accepted input beat itself and compares each output beat in order.
// Depends on tcsp_pkg for the phase, kind and result types and the signature bytes.
`default_nettype none

module tcsp_result_checker #(
  parameter int MAX_TABLES   = tcsp_pkg::DEF_MAX_TABLES,
  parameter int NAME_LIMIT   = tcsp_pkg::DEF_NAME_LIMIT,
  parameter int MAX_ELEMENTS = tcsp_pkg::DEF_MAX_ELEMENTS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [1:0]  out_kind,
  input  wire logic [5:0]  out_table_index,
  input  wire logic [15:0] out_value,
  input  wire logic [19:0] out_element_index,
  input  wire logic [20:0] out_row_count,
  input  wire logic [20:0] out_column_count,
  input  wire logic        out_status,
  input  wire logic        out_run_end,
  output int               mismatches,
  output int               results_matched,
  output int               results_due
);
  import tcsp_pkg::*;

  localparam logic [31:0] SIGNATURE = {SIG_B3, SIG_B2, SIG_B1, SIG_B0};

  // own copy of the parse state
  phase_t      ph;
  logic [1:0]  bpos;
  logic [31:0] acc;
  logic [6:0]  tabs_decl;
  logic [6:0]  tab_cur;
  logic [5:0]  name_left;
  logic [20:0] rows_r;
  logic [20:0] cols_r;
  logic [20:0] elems_left;
  logic [19:0] elem_idx;
  logic [7:0]  low_hold;
  logic        broken;

  out_item_t parsed_results [$];
  out_item_t want;

  task automatic restart_stream();
    ph         = PH_MAGIC;
    bpos       = '0;
    acc        = '0;
    tabs_decl  = '0;
    tab_cur    = '0;
    name_left  = '0;
    rows_r     = '0;
    cols_r     = '0;
    elems_left = '0;
    elem_idx   = '0;
    low_hold   = '0;
    broken     = 1'b0;
  endtask

  function automatic out_item_t blank_result(kind_t k, logic [5:0] tab);
    out_item_t r;
    r             = '0;
    r.kind        = k;
    r.table_index = tab;
    return r;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic fin);
    out_item_t   res [2];
    out_item_t   r;
    int          n;
    logic [31:0] w;
    logic        wdone;
    logic [63:0] total;
    n     = 0;
    w     = '0;
    wdone = 1'b0;
    if (!broken) begin
      if (ph == PH_COUNT || ph == PH_NAMELEN || ph == PH_ROWS || ph == PH_COLS) begin
        acc = acc | ({24'd0, b} << (8 * bpos));
        if (bpos < 2'd3) begin
          bpos++;
        end else begin
          w     = acc;
          acc   = '0;
          bpos  = '0;
          wdone = 1'b1;
        end
      end
      case (ph)
        PH_MAGIC: begin
          if (b != SIGNATURE[8*bpos +: 8]) begin
            broken = 1'b1;
          end else if (bpos == 2'd3) begin
            bpos = '0;
            ph   = PH_COUNT;
          end else begin
            bpos++;
          end
        end
        PH_COUNT: begin
          if (wdone) begin
            if (w == 0 || w > MAX_TABLES) begin
              broken = 1'b1;
            end else begin
              tabs_decl = w[6:0];
              tab_cur   = '0;
              ph        = PH_NAMELEN;
            end
          end
        end
        PH_NAMELEN: begin
          if (wdone) begin
            if (w == 0 || w > NAME_LIMIT) begin
              broken = 1'b1;
            end else begin
              name_left = w[5:0];
              ph        = PH_NAME;
            end
          end
        end
        PH_NAME: begin
          r       = blank_result(KIND_NAME, tab_cur[5:0]);
          r.value = {8'd0, b};
          res[n]  = r;
          n++;
          name_left--;
          if (name_left == 0) ph = PH_ROWS;
        end
        PH_ROWS: begin
          if (wdone) begin
            if (w == 0 || w > MAX_ELEMENTS) begin
              broken = 1'b1;
            end else begin
              rows_r = w[20:0];
              ph     = PH_COLS;
            end
          end
        end
        PH_COLS: begin
          if (wdone) begin
            // 64-bit product so that a wrapped 32-bit size cannot slip through
            total = {43'd0, rows_r} * {32'd0, w};
            if (w == 0 || total > MAX_ELEMENTS) begin
              broken = 1'b1;
            end else begin
              cols_r         = w[20:0];
              elems_left     = total[20:0];
              elem_idx       = '0;
              r              = blank_result(KIND_DIMS, tab_cur[5:0]);
              r.row_count    = rows_r;
              r.column_count = cols_r;
              res[n]         = r;
              n++;
              ph             = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          if (bpos == 2'd0) begin
            low_hold = b;
            bpos     = 2'd1;
          end else begin
            bpos            = '0;
            r               = blank_result(KIND_ELEM, tab_cur[5:0]);
            r.value         = {b, low_hold};
            r.element_index = elem_idx;
            res[n]          = r;
            n++;
            elem_idx++;
            elems_left--;
            if (elems_left == 0) begin
              tab_cur++;
              ph = (tab_cur >= tabs_decl) ? PH_DONE : PH_NAMELEN;
            end
          end
        end
        default: broken = 1'b1;
      endcase
    end
    if (broken) n = 0;
    if (fin) begin
      r        = blank_result(KIND_END, 6'd0);
      r.status = broken || ph != PH_DONE;
      res[n]   = r;
      n++;
      restart_stream();
    end
    if (n > 0) res[n-1].run_end = 1'b1;
    for (int i = 0; i < n; i++) parsed_results.push_back(res[i]);
  endtask

  task automatic check_field(input string name, input logic [20:0] exp_v,
                             input logic [20:0] got_v);
    if (exp_v !== got_v) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, got_v);
    end
  endtask

  initial restart_stream();

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (parsed_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat: expected none, got kind %0d value %0d",
                   $time, out_kind, out_value);
        end else begin
          want = parsed_results.pop_front();
          check_field("kind", 21'(want.kind), 21'(out_kind));
          check_field("table_index", 21'(want.table_index), 21'(out_table_index));
          check_field("value", 21'(want.value), 21'(out_value));
          check_field("element_index", 21'(want.element_index),
                      21'(out_element_index));
          check_field("row_count", want.row_count, out_row_count);
          check_field("column_count", want.column_count, out_column_count);
          check_field("status", 21'(want.status), 21'(out_status));
          check_field("run_end", 21'(want.run_end), 21'(out_run_end));
          results_matched++;
        end
      end
      if (in_valid && !in_stall) parse_byte(in_data_byte, in_last);
    end
    results_due <= parsed_results.size();
  end

endmodule

`default_nettype wire

// ===== sim/tb_table_container_stream_parser.sv =====
// Testbench top for the table container stream parser: builds container streams,
// directed edge cases first and then random ones, and gives the verdict.
// Depends on tcsp_pkg, table_container_stream_parser and tcsp_result_checker.
`default_nettype none

module tb_table_container_stream_parser;
  import tcsp_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  // directed streams carry about 1310 bytes, random ones top the run up
  localparam int RANDOM_BYTES = 140;
  localparam logic [31:0] SIGNATURE = {SIG_B3, SIG_B2, SIG_B1, SIG_B0};

  logic        clk;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_last      = 1'b0;
  logic        out_stall    = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [1:0]  out_kind;
  logic [5:0]  out_table_index;
  logic [15:0] out_value;
  logic [19:0] out_element_index;
  logic [20:0] out_row_count;
  logic [20:0] out_column_count;
  logic        out_status;
  logic        out_run_end;

  int mismatches;
  int results_matched;
  int results_due;
  int cycles       = 0;
  int streams_sent = 0;
  int bytes_sent   = 0;
  bit calm         = 1'b0;

  logic [7:0] stream_bytes [$];

  table_container_stream_parser i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_table_index  (out_table_index),
    .out_value        (out_value),
    .out_element_index(out_element_index),
    .out_row_count    (out_row_count),
    .out_column_count (out_column_count),
    .out_status       (out_status),
    .out_run_end      (out_run_end)
  );

  tcsp_result_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_table_index  (out_table_index),
    .out_value        (out_value),
    .out_element_index(out_element_index),
    .out_row_count    (out_row_count),
    .out_column_count (out_column_count),
    .out_status       (out_status),
    .out_run_end      (out_run_end),
    .mismatches       (mismatches),
    .results_matched  (results_matched),
    .results_due      (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_table_container_stream_parser: errors");
      $finish;
    end
  end

  // receiver: random stall before each result beat, none in calm stretches
  initial begin
    int hold;
    wait (rst_n);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 10);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic put_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) stream_bytes.push_back(w[8*i +: 8]);
  endtask

  task automatic put_noise(input int count);
    repeat (count) stream_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic put_header(input logic [31:0] count);
    for (int i = 0; i < 4; i++) stream_bytes.push_back(SIGNATURE[8*i +: 8]);
    put_word(count);
  endtask

  task automatic put_table(input int title_len, input int rows, input int cols);
    put_word(title_len);
    put_noise(title_len);
    put_word(rows);
    put_word(cols);
    put_noise(2 * rows * cols);
  endtask

  // valid stays up across back-to-back beats, lowered only for a gap
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last      <= fin;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_stream();
    int n;
    n = stream_bytes.size();
    for (int i = 0; i < n; i++) send_byte(stream_bytes[i], i == n - 1);
    streams_sent++;
    bytes_sent += n;
    stream_bytes.delete();
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  initial begin
    int pick;
    int tabs;
    int keep;
    int idx;
    int random_bytes;
    random_bytes = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // well formed, longest name, extreme byte and element values
    put_header(2);
    put_word(32);
    stream_bytes.push_back(8'h00);
    stream_bytes.push_back(8'hFF);
    put_noise(30);
    put_word(1);
    put_word(2);
    stream_bytes.push_back(8'h00);
    stream_bytes.push_back(8'h00);
    stream_bytes.push_back(8'hFF);
    stream_bytes.push_back(8'hFF);
    put_table(1, 2, 1);
    send_stream();

    // bad signature at each position
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 4; i++)
        stream_bytes.push_back(SIGNATURE[8*i +: 8] ^ ((i == k) ? (8'h01 << k) : 8'h00));
      put_noise(2);
      send_stream();
    end

    // table count out of range
    put_header(0);
    send_stream();
    put_header(65);
    put_noise(3);
    send_stream();
    put_header(32'hFFFF_FFFF);
    send_stream();

    // name length out of range
    put_header(1);
    put_word(0);
    send_stream();
    put_header(1);
    put_word(33);
    put_noise(1);
    send_stream();

    // rows and cols bounds
    put_header(1);
    put_word(1);
    put_noise(1);
    put_word(0);
    send_stream();
    put_header(1);
    put_word(1);
    put_noise(1);
    put_word(32'd1048577);
    send_stream();
    // largest size accepted, stream ends on the last cols beat
    put_header(1);
    put_word(4);
    put_noise(4);
    put_word(32'd1048576);
    put_word(1);
    send_stream();
    put_header(1);
    put_word(2);
    put_noise(2);
    put_word(3);
    put_word(0);
    send_stream();
    put_header(1);
    put_word(1);
    put_noise(1);
    put_word(1024);
    put_word(1025);
    send_stream();
    // size product wraps to zero in 32 bits
    put_header(1);
    put_word(1);
    put_noise(1);
    put_word(32'd1048576);
    put_word(32'd4096);
    send_stream();
    // truncated inside the data
    put_header(1);
    put_word(1);
    put_noise(1);
    put_word(1);
    put_word(32'd1048576);
    put_noise(6);
    send_stream();

    // trailing byte after a complete container
    put_header(1);
    put_table(2, 1, 1);
    put_noise(1);
    send_stream();
    // stream ends on a name byte
    put_header(1);
    put_word(5);
    put_noise(2);
    send_stream();
    stream_bytes.push_back(SIG_B0);
    send_stream();
    put_header(3);
    send_stream();

    drain_results();
    // most tables allowed, all minimal
    put_header(64);
    repeat (64) put_table(1, 1, 1);
    send_stream();
    drain_results();

    // random containers, mostly well formed
    while (random_bytes < RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 11) == 0) drain_results();
      if (pick < 8) begin
        put_noise($urandom_range(1, 8));
      end else begin
        tabs = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
        put_header(tabs);
        repeat (tabs)
          put_table(($urandom_range(0, 7) == 0) ? $urandom_range(1, 32) : $urandom_range(1, 4),
                    $urandom_range(1, 3), $urandom_range(1, 3));
        if (pick < 30) begin
          case ($urandom_range(0, 2))
            0: begin
              keep = $urandom_range(1, stream_bytes.size() - 1);
              while (stream_bytes.size() > keep) void'(stream_bytes.pop_back());
            end
            1: begin
              idx = $urandom_range(0, stream_bytes.size() - 1);
              stream_bytes[idx] = 8'($urandom_range(0, 255));
            end
            default: put_noise($urandom_range(1, 3));
          endcase
        end
      end
      random_bytes += stream_bytes.size();
      send_stream();
    end

    calm = 1'b0;
    drain_results();
    repeat (20) @(posedge clk);
    $display("sent %0d streams, %0d bytes (%0d in random containers)",
             streams_sent, bytes_sent, random_bytes);
    $display("compared %0d result beats, %0d mismatches", results_matched, mismatches);
    if (mismatches == 0) begin
      $display("tb_table_container_stream_parser: clean");
    end else begin
      $display("tb_table_container_stream_parser: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/tcsp_pkg.sv
rtl/tcsp_parser.sv
rtl/tcsp_out_fifo.sv
rtl/table_container_stream_parser.sv
sim/tcsp_result_checker.sv
sim/tb_table_container_stream_parser.sv
